@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL of the sorted key table; only the sequencer includes them.
// Depends on nothing; users provide i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hw/rtl/skct_pkg.sv @@
// Types, constants and the name hashing function of the sorted key table.
// Used by the cell, the controller and the top level; depends on nothing.
package skct_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_IDX_W   = 6;
    localparam int KEY_W       = 32;
    localparam int NAME_BYTES  = 8;
    localparam int LANES       = 4;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_GET      = 2'd1,
        OP_CLEAN    = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NONE      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             seq;
        logic             res;
        logic [31:0]      stamp;
    } t_entry;

    typedef struct packed {
        t_status                status;
        logic [OUT_IDX_W-1:0]   idx;
        logic [KEY_W-1:0]       key;
        logic                   load;
        logic                   seq;
        logic                   last;
    } t_result;

    function automatic logic [KEY_W-1:0] name_key(input logic [8*NAME_BYTES-1:0] name);
        logic [KEY_W-1:0] key;
        logic             ended;
        key   = '0;
        ended = 1'b0;
        for (int b = 0; b < NAME_BYTES; b++) begin
            if (name[8*b +: 8] == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                key[8*(b % LANES) +: 8] = key[8*(b % LANES) +: 8] | name[8*b +: 8];
            end
        end
        return key;
    endfunction

endpackage

@@ hw/rtl/skct_cell.sv @@
// One table entry of the rotating chain: takes its neighbor's entry on a shift.
// Depends on skct_pkg.
module skct_cell
    import skct_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_next,
    output t_entry o_entry
);

    logic        r_res;
    logic [31:0] r_key;
    logic        r_seq;
    logic [31:0] r_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= 1'b0;
        end else if (i_shift) begin
            r_res <= i_next.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key   <= i_next.key;
            r_seq   <= i_next.seq;
            r_stamp <= i_next.stamp;
        end
    end

    assign o_entry = '{key: r_key, seq: r_seq, res: r_res, stamp: r_stamp};

endmodule

@@ hw/rtl/skct_ctrl.sv @@
// Sequencer at the head of the entry chain: inserts, searches and releases as
// entries rotate past, and holds the output register. Depends on skct_pkg.
`include "assert_macros.svh"
module skct_ctrl
    import skct_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_opcode,
    input  logic [8*NAME_BYTES-1:0]  i_file_name,
    input  logic                     i_has_sequences,
    input  logic [31:0]              i_frame_number,
    input  t_entry                   i_head,
    output t_entry                   o_tail,
    output logic                     o_shift,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_result                  o_out
);

    t_state              r_state, n_state;
    t_opcode             r_op;
    logic [KEY_W-1:0]    r_key;
    logic                r_seq;
    logic [31:0]         r_frame;
    logic [CNT_W-1:0]    r_step;
    logic [CNT_W-1:0]    r_count;
    logic                r_done;
    logic                r_pend_v;
    t_entry              r_carry;
    t_result             r_pend;
    t_result             r_out;
    logic                r_out_v;

    logic                w_accept;
    logic                w_full;
    logic                w_live;
    logic                w_slot_free;
    logic                w_last_step;
    logic                w_hit_ins;
    logic                w_hit_get;
    logic                w_rel;
    logic                w_want;
    logic                w_emit;
    logic                w_advance;
    t_result             w_emit_data;
    t_result             w_init_pend;
    t_entry              w_tail;
    logic [IDX_W-1:0]    w_idx;
    logic [KEY_W-1:0]    w_in_key;

    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_full      = (r_count >= CNT_W'(TABLE_DEPTH));
    assign w_live      = (r_step < r_count);
    assign w_slot_free = !r_out_v || !i_out_stall;
    assign w_last_step = (r_step == CNT_W'(TABLE_DEPTH - 1));
    assign w_idx       = r_step[IDX_W-1:0];
    assign w_in_key    = name_key(i_file_name);

    always_comb begin
        w_init_pend = '{status: STAT_NONE, idx: '0, key: '0, load: 1'b0, seq: 1'b0,
                        last: 1'b1};
        case (t_opcode'(i_opcode))
            OP_REGISTER: begin
                w_init_pend.status = STAT_FULL;
                w_init_pend.key    = w_in_key;
            end
            OP_GET: begin
                w_init_pend.status = STAT_NOT_FOUND;
                w_init_pend.key    = w_in_key;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (t_opcode'(i_opcode))
                        OP_REGISTER: n_state = w_full ? ST_FINISH : ST_SWEEP;
                        OP_GET:      n_state = ST_SWEEP;
                        OP_CLEAN:    n_state = ST_SWEEP;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SWEEP: begin
                if (w_advance && w_last_step) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_hit_ins   = 1'b0;
        w_hit_get   = 1'b0;
        w_rel       = 1'b0;
        w_want      = 1'b0;
        w_emit_data = r_pend;
        w_tail      = i_head;
        case (r_state)
            ST_SWEEP: begin
                case (r_op)
                    OP_REGISTER: begin
                        w_hit_ins = !r_done && (!w_live || (i_head.key > r_key));
                        if (w_hit_ins) begin
                            w_tail = '{key: r_key, seq: r_seq, res: 1'b0, stamp: '0};
                        end else if (r_done) begin
                            w_tail = r_carry;
                        end
                    end
                    OP_GET: begin
                        w_hit_get = !r_done && w_live && (i_head.key == r_key);
                        if (w_hit_get) begin
                            w_tail.res   = 1'b1;
                            w_tail.stamp = r_frame;
                        end
                    end
                    OP_CLEAN: begin
                        w_rel = w_live && i_head.res && (i_head.stamp != r_frame);
                        if (w_rel) begin
                            w_tail.res = 1'b0;
                        end
                        w_want           = w_rel && r_pend_v;
                        w_emit_data.last = 1'b0;
                    end
                    default: ;
                endcase
            end
            ST_FINISH: begin
                w_want = 1'b1;
            end
            default: ;
        endcase
        w_emit    = w_want && w_slot_free;
        w_advance = !w_want || w_slot_free;
    end

    assign o_shift = (r_state == ST_SWEEP) && w_advance;
    assign o_tail  = w_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_step   <= '0;
            r_done   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_step   <= '0;
                r_done   <= 1'b0;
                r_pend_v <= 1'b0;
            end else if (o_shift) begin
                r_step <= r_step + CNT_W'(1);
                if (w_hit_ins) begin
                    r_done  <= 1'b1;
                    r_count <= r_count + CNT_W'(1);
                end
                if (w_hit_get) begin
                    r_done <= 1'b1;
                end
                if (w_rel) begin
                    r_pend_v <= 1'b1;
                end
            end
            if (w_emit) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= t_opcode'(i_opcode);
            r_key   <= w_in_key;
            r_seq   <= i_has_sequences;
            r_frame <= i_frame_number;
            r_pend  <= w_init_pend;
        end else if (o_shift) begin
            if (w_hit_ins || r_done) begin
                r_carry <= i_head;
            end
            if (w_hit_ins) begin
                r_pend <= '{status: STAT_OK, idx: OUT_IDX_W'(w_idx), key: r_key,
                            load: 1'b0, seq: r_seq, last: 1'b1};
            end
            if (w_hit_get) begin
                r_pend <= '{status: STAT_OK, idx: OUT_IDX_W'(w_idx), key: r_key,
                            load: !i_head.res, seq: i_head.seq, last: 1'b1};
            end
            if (w_rel) begin
                r_pend <= '{status: STAT_OK, idx: OUT_IDX_W'(w_idx), key: i_head.key,
                            load: 1'b0, seq: i_head.seq, last: 1'b1};
            end
        end
        if (w_emit) begin
            r_out <= w_emit_data;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    `ASSERT_CLKD(a_count_bound, (r_count <= CNT_W'(TABLE_DEPTH)), "entry count beyond depth")
    `ASSERT_CLKD(a_shift_in_sweep, (o_shift |-> (r_state == ST_SWEEP)), "chain moved outside sweep")
    `ASSERT_CLKD(a_finish_emits, ((r_state == ST_FINISH && n_state == ST_IDLE) |-> w_emit),
                 "operation ended without final word")
    `ASSERT_CLKD(a_insert_done,
                 ((r_state == ST_SWEEP && n_state == ST_FINISH && r_op == OP_REGISTER)
                  |-> (r_done || w_hit_ins)), "register sweep ended without insertion")
    `ASSERT_CLKD(a_emit_has_slot, (w_emit |-> w_slot_free), "word overwrote pending output")

endmodule

@@ hw/rtl/sorted_key_cache_table.sv @@
// Top level of the sorted key table: a rotating chain of entry cells and the
// sequencer at its head. Depends on skct_pkg, skct_cell and skct_ctrl.
//
//   channel   valid        stall        payload
//   input     i_in_valid   o_in_stall   i_opcode i_file_name i_has_sequences i_frame_number
//   output    o_out_valid  i_out_stall  o_status o_entry_index o_entry_key o_needs_load
//                                       o_entry_sequences o_last_result
//
// Register, get and clean each rotate the whole chain once, and the rotation
// pauses while an output stall meets a pending word.
// A register into a full table and an unused opcode take no rotation.
// The input is stalled while an operation is in progress; reset is synchronous.
module sorted_key_cache_table
    import skct_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_opcode,
    input  logic [63:0]             i_file_name,
    input  logic                    i_has_sequences,
    input  logic [31:0]             i_frame_number,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_status,
    output logic [5:0]              o_entry_index,
    output logic [31:0]             o_entry_key,
    output logic                    o_needs_load,
    output logic                    o_entry_sequences,
    output logic                    o_last_result
);

    t_entry  w_cell [TABLE_DEPTH];
    t_entry  w_tail;
    logic    w_shift;
    t_result w_out;

    for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
        if (j == TABLE_DEPTH - 1) begin : g_end
            skct_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_next  (w_tail),
                .o_entry (w_cell[j])
            );
        end else begin : g_mid
            skct_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_next  (w_cell[j+1]),
                .o_entry (w_cell[j])
            );
        end
    end

    skct_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_file_name     (i_file_name),
        .i_has_sequences (i_has_sequences),
        .i_frame_number  (i_frame_number),
        .i_head          (w_cell[0]),
        .o_tail          (w_tail),
        .o_shift         (w_shift),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out           (w_out)
    );

    assign o_status          = w_out.status;
    assign o_entry_index     = w_out.idx;
    assign o_entry_key       = w_out.key;
    assign o_needs_load      = w_out.load;
    assign o_entry_sequences = w_out.seq;
    assign o_last_result     = w_out.last;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the sorted key table. It covers register, get and clean,
// the full table, and random traffic with idle input gaps and output stalls.
// Depends on skct_pkg and sorted_key_cache_table.
module testbench;
    import skct_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
    localparam int MAX_GAP = 10;
    localparam int REPORT_LIMIT = 10;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_opcode = 2'd0;
    logic [63:0] i_file_name = 64'd0;
    logic        i_has_sequences = 1'b0;
    logic [31:0] i_frame_number = 32'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [5:0]  o_entry_index;
    logic [31:0] o_entry_key;
    logic        o_needs_load;
    logic        o_entry_sequences;
    logic        o_last_result;

    logic [31:0] tbl_key [TABLE_DEPTH];
    logic        tbl_seq [TABLE_DEPTH];
    logic        tbl_res [TABLE_DEPTH];
    logic [31:0] tbl_stamp [TABLE_DEPTH];
    int          tbl_count = 0;

    t_result     pending_results[$];
    logic [63:0] name_pool[$];
    logic [31:0] cur_frame = 32'd1;

    int unsigned tx_gap = 0;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    int unsigned rx_wait = 0;
    int unsigned rx_next;
    logic        rx_hold = 1'b0;
    int unsigned hold_request = 0;
    int unsigned cycle_count = 0;

    int n_items = 0;
    int n_register = 0;
    int n_get = 0;
    int n_clean = 0;
    int n_full = 0;
    int n_released = 0;
    int n_words = 0;
    int mismatch_count = 0;

    sorted_key_cache_table dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_file_name      (i_file_name),
        .i_has_sequences  (i_has_sequences),
        .i_frame_number   (i_frame_number),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_entry_index    (o_entry_index),
        .o_entry_key      (o_entry_key),
        .o_needs_load     (o_needs_load),
        .o_entry_sequences(o_entry_sequences),
        .o_last_result    (o_last_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d result words outstanding.",
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] key_of_name(input logic [63:0] name);
        logic [31:0] k;
        k = '0;
        for (int n = 0; n < 8; n++) begin
            if (name[8*n +: 8] == 8'h00) break;
            k[8*(n & 3) +: 8] = k[8*(n & 3) +: 8] | name[8*n +: 8];
        end
        return k;
    endfunction

    function automatic void queue_result(input t_status st, input int idx,
                                         input logic [31:0] key, input logic load,
                                         input logic seq, input logic last);
        t_result r;
        r.status = st;
        r.idx    = idx[OUT_IDX_W-1:0];
        r.key    = key;
        r.load   = load;
        r.seq    = seq;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    task automatic apply_to_table(input logic [1:0] op, input logic [63:0] name,
                                  input logic seq, input logic [31:0] frame);
        logic [31:0] key;
        int pos;
        int found;
        int released[$];
        key = key_of_name(name);
        case (op)
            OP_REGISTER: begin
                n_register++;
                if (tbl_count >= TABLE_DEPTH) begin
                    n_full++;
                    queue_result(STAT_FULL, 0, key, 1'b0, 1'b0, 1'b1);
                end else begin
                    pos = tbl_count;
                    while (pos > 0 && tbl_key[pos-1] > key) begin
                        tbl_key[pos]   = tbl_key[pos-1];
                        tbl_seq[pos]   = tbl_seq[pos-1];
                        tbl_res[pos]   = tbl_res[pos-1];
                        tbl_stamp[pos] = tbl_stamp[pos-1];
                        pos--;
                    end
                    tbl_key[pos]   = key;
                    tbl_seq[pos]   = seq;
                    tbl_res[pos]   = 1'b0;
                    tbl_stamp[pos] = 32'd0;
                    tbl_count++;
                    queue_result(STAT_OK, pos, key, 1'b0, seq, 1'b1);
                end
            end
            OP_GET: begin
                n_get++;
                found = -1;
                for (int e = 0; e < tbl_count; e++) begin
                    if (found < 0 && tbl_key[e] == key) found = e;
                end
                if (found < 0) begin
                    queue_result(STAT_NOT_FOUND, 0, key, 1'b0, 1'b0, 1'b1);
                end else begin
                    queue_result(STAT_OK, found, key, !tbl_res[found], tbl_seq[found], 1'b1);
                    tbl_res[found]   = 1'b1;
                    tbl_stamp[found] = frame;
                end
            end
            OP_CLEAN: begin
                n_clean++;
                for (int e = 0; e < tbl_count; e++) begin
                    if (tbl_res[e] && tbl_stamp[e] != frame) begin
                        tbl_res[e] = 1'b0;
                        released.push_back(e);
                    end
                end
                n_released += released.size();
                if (released.size() == 0) begin
                    queue_result(STAT_NONE, 0, 32'd0, 1'b0, 1'b0, 1'b1);
                end else begin
                    foreach (released[j]) begin
                        queue_result(STAT_OK, released[j], tbl_key[released[j]], 1'b0,
                                     tbl_seq[released[j]], j == released.size() - 1);
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic void check_result_word();
        t_result want;
        n_words++;
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("Unexpected result word: status=%0d index=%0d key=%h load=%b seq=%b last=%b",
                         o_status, o_entry_index, o_entry_key, o_needs_load,
                         o_entry_sequences, o_last_result);
            end
            return;
        end
        want = pending_results.pop_front();
        if (o_status !== want.status || o_entry_index !== want.idx ||
            o_entry_key !== want.key || o_needs_load !== want.load ||
            o_entry_sequences !== want.seq || o_last_result !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("Result word %0d expected: status=%0d index=%0d key=%h load=%b seq=%b last=%b",
                         n_words, want.status, want.idx, want.key, want.load, want.seq, want.last);
                $display("Result word %0d actual:   status=%0d index=%0d key=%h load=%b seq=%b last=%b",
                         n_words, o_status, o_entry_index, o_entry_key, o_needs_load,
                         o_entry_sequences, o_last_result);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait     <= 0;
        end else begin
            rx_next = rx_wait;
            if (o_out_valid && !i_out_stall) begin
                check_result_word();
                rx_next = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end else if (rx_next != 0) begin
                rx_next = rx_next - 1;
            end
            rx_wait     <= rx_next;
            i_out_stall <= rx_hold || (rx_next != 0);
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                rx_hold <= 1'b1;
                repeat (hold_request) @(posedge i_clk);
                rx_hold <= 1'b0;
                hold_request = 0;
            end
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [63:0] name,
                             input logic seq, input logic [31:0] frame);
        repeat (tx_gap) @(posedge i_clk);
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_file_name     <= name;
        i_has_sequences <= seq;
        i_frame_number  <= frame;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_to_table(op, name, seq, frame);
        n_items++;
        tx_gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (tx_gap != 0) i_in_valid <= 1'b0;
    endtask

    task automatic drain_results();
        if (tx_gap == 0) i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Names either use all eight bytes or end early with junk after the terminator.
    // A small alphabet makes equal keys from different names likely.
    function automatic logic [63:0] random_name();
        logic [63:0] nm;
        int len;
        int kind;
        nm   = {$urandom, $urandom};
        len  = $urandom_range(0, 8);
        kind = $urandom_range(0, 2);
        if (kind == 1) begin
            for (int b = 0; b < len; b++) nm[8*b +: 8] = 8'h41 + 8'($urandom_range(0, 3));
        end else if (kind == 2) begin
            for (int b = 0; b < len; b++) if (nm[8*b +: 8] == 8'h00) nm[8*b +: 8] = 8'h80;
        end
        if (kind != 0 && len < 8) nm[8*len +: 8] = 8'h00;
        return nm;
    endfunction

    function automatic logic [63:0] known_name();
        if (name_pool.size() == 0) return random_name();
        return name_pool[$urandom_range(0, name_pool.size() - 1)];
    endfunction

    task automatic register_name(input logic [63:0] name, input logic seq);
        name_pool.push_back(name);
        send_word(OP_REGISTER, name, seq, $urandom);
    endtask

    task automatic test_empty_table();
        send_word(OP_GET, 64'h41, 1'b0, 32'd1);
        send_word(OP_CLEAN, 64'd0, 1'b0, 32'd0);
        send_word(OP_UNUSED, '1, 1'b1, '1);
    endtask

    task automatic test_key_forming_and_order();
        register_name(64'd0, 1'b1);
        register_name('1, 1'b0);
        register_name(64'h4847_4645_4443_4241, 1'b0);
        register_name(64'hFFFF_FFFF_0043_4241, 1'b1);
        register_name(64'h4847_4645_4443_4241, 1'b1);
        register_name(64'h0000_0000_0000_0001, 1'b0);
        register_name(64'h0000_0000_0000_0080, 1'b1);
        register_name(64'h8000_0000_0000_0000, 1'b0);
    endtask

    task automatic test_get_and_clean();
        send_word(OP_GET, 64'h4847_4645_4443_4241, 1'b0, 32'd5);
        send_word(OP_GET, 64'h4847_4645_4443_4241, 1'b1, 32'd5);
        send_word(OP_GET, 64'd0, 1'b0, 32'hFFFF_FFFF);
        send_word(OP_GET, 64'h5A, 1'b1, 32'd5);
        send_word(OP_CLEAN, 64'd0, 1'b0, 32'd5);
        send_word(OP_CLEAN, 64'd0, 1'b0, 32'd5);
        send_word(OP_CLEAN, 64'd0, 1'b0, 32'd0);
        send_word(OP_GET, '1, 1'b0, 32'd0);
        send_word(OP_CLEAN, '1, 1'b1, 32'd0);
        send_word(OP_GET, 64'hFFFF_FFFF_0043_4241, 1'b0, 32'hFFFF_FFFF);
        send_word(OP_CLEAN, 64'd0, 1'b0, 32'hFFFF_FFFF);
        send_word(OP_GET, 64'h0000_0000_0000_0001, 1'b0, 32'h8000_0000);
        send_word(OP_GET, 64'h0000_0000_0000_0080, 1'b1, 32'd7);
        send_word(OP_CLEAN, 64'd0, 1'b0, 32'd0);
    endtask

    task automatic test_random_traffic(input int count);
        logic [31:0] fr;
        int pick;
        int done;
        done = 0;
        while (done < count) begin
            if (done % 40 == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                send_word(OP_UNUSED, {$urandom, $urandom}, 1'($urandom_range(0, 1)), $urandom);
            end else begin
                done++;
                if (pick < 24) begin
                    if ($urandom_range(0, 3) == 0) register_name(known_name(), 1'($urandom_range(0, 1)));
                    else register_name(random_name(), 1'($urandom_range(0, 1)));
                end else if (pick < 76) begin
                    if ($urandom_range(0, 4) != 0) begin
                        send_word(OP_GET, known_name(), 1'($urandom_range(0, 1)), cur_frame);
                    end else begin
                        send_word(OP_GET, random_name(), 1'($urandom_range(0, 1)), cur_frame);
                    end
                end else begin
                    fr = ($urandom_range(0, 9) < 7) ? cur_frame : 32'($urandom);
                    send_word(OP_CLEAN, {$urandom, $urandom}, 1'($urandom_range(0, 1)), fr);
                    cur_frame = cur_frame + 32'($urandom_range(1, 3));
                    case ($urandom_range(0, 19))
                        0: cur_frame = 32'd0;
                        1: cur_frame = 32'hFFFF_FFFE;
                        2: cur_frame = $urandom;
                        default: ;
                    endcase
                end
            end
        end
    endtask

    task automatic test_table_full();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        while (tbl_count < TABLE_DEPTH) register_name(random_name(), 1'($urandom_range(0, 1)));
        send_word(OP_REGISTER, 64'd0, 1'b1, 32'd0);
        send_word(OP_REGISTER, '1, 1'b1, '1);
        send_word(OP_REGISTER, known_name(), 1'b0, $urandom);
        for (int n = 0; n < 4; n++) send_word(OP_GET, known_name(), 1'b0, 32'hFFFF_FFFF);
        send_word(OP_CLEAN, 64'd0, 1'b0, 32'd0);
    endtask

    // The receiver holds off long enough that the table backs up and stalls its input.
    task automatic test_output_backpressure();
        tx_quiet     = 1'b1;
        rx_quiet     = 1'b0;
        hold_request = 400;
        for (int n = 0; n < 5; n++) send_word(OP_GET, known_name(), 1'b0, cur_frame);
        send_word(OP_CLEAN, 64'd0, 1'b0, cur_frame + 32'd7);
        for (int n = 0; n < 5; n++) send_word(OP_GET, known_name(), 1'b1, cur_frame);
        send_word(OP_CLEAN, 64'd0, 1'b0, cur_frame + 32'd9);
        tx_quiet = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_key_forming_and_order();
        test_get_and_clean();
        test_random_traffic(320);
        test_table_full();
        test_output_backpressure();
        drain_results();
        $display("Sent %0d input words: %0d register, %0d get, %0d clean; checked %0d result words.",
                 n_items, n_register, n_get, n_clean, n_words);
        $display("Table-full rejects: %0d, entries released by clean: %0d, mismatches: %0d.",
                 n_full, n_released, mismatch_count);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
